// ----- design/mhpq_pkg.sv -----
// Shared constants and types for the min-heap priority queue.
// Has no dependencies; the top level imports it.
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- design/min_heap_priority_queue.sv -----
// Top level of the min-heap priority queue: command sequencer around the heap RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
// A command is taken when start is high and busy is low; in the cycle after the
// command finishes, done pulses for a single cycle with result_value, status
// and count, and busy drops in that same cycle so the next command can start
// there. The results cannot be held off. The heap lives in one RAM with one
// read and one write per cycle and a registered read, so the sift loops set
// the time. Insert opens a hole at the end and climbs: each level reads the
// parent, then moves it down into the hole if the new value is smaller.
// Extract reads the root, then sifts the last entry down: each level reads
// the left and right child and moves the smaller child up if it is below
// that entry. Peek reads the root; a rejected or unknown command ends in idle.
module min_heap_priority_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mhpq_pkg::CMD_W-1:0]     cmd,
    input  mhpq_pkg::data_t                value,
    output logic                           busy,
    output logic                           done,
    output mhpq_pkg::data_t                result_value,
    output logic [mhpq_pkg::STATUS_W-1:0]  status,
    output logic [mhpq_pkg::COUNT_W-1:0]   count
);

    import mhpq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_RT_RD  = 4'd3;
    localparam logic [3:0] S_LAST   = 4'd4;
    localparam logic [3:0] S_DN_RL  = 4'd5;
    localparam logic [3:0] S_DN_RR  = 4'd6;
    localparam logic [3:0] S_DN_CMP = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    data_t               hold_reg, hold_next;
    data_t               left_reg, left_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    data_t               res_reg, res_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                extract_reg, extract_next;
    logic                done_reg, done_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    data_t               wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [DATA_W-1:0]   rd_raw;
    data_t               rd_val;

    logic [IDX_W-1:0]    lc_idx;
    logic [IDX_W-1:0]    rc_idx;
    logic [IDX_W-1:0]    fill_ext;
    logic [ADDR_W-1:0]   parent;
    logic [FILL_W-1:0]   last_idx;
    logic                go_left;
    logic                go_right;
    data_t               min_lh;

    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_val   = rd_raw;
    assign lc_idx   = {1'b0, pos_reg, 1'b1};
    assign rc_idx   = lc_idx + IDX_W'(1);
    assign fill_ext = IDX_W'(fill_reg);
    assign parent   = (pos_reg - ADDR_W'(1)) >> 1;
    assign last_idx = fill_reg - FILL_W'(1);

    // Left child wins ties: the right child must be strictly below both.
    assign go_left  = (left_reg < hold_reg);
    assign min_lh   = go_left ? left_reg : hold_reg;
    assign go_right = (rc_idx < fill_ext) && (rd_val < min_lh);

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        left_next    = left_reg;
        fill_next    = fill_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        extract_next = extract_reg;
        done_next    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = hold_reg;
        rd_addr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next    = '0;
                    status_next = ST_OK;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (fill_reg == FILL_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                hold_next  = value;
                                pos_next   = fill_reg[ADDR_W-1:0];
                                fill_next  = fill_reg + FILL_W'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        CMD_EXTRACT, CMD_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                rd_addr      = '0;
                                extract_next = (cmd == CMD_EXTRACT);
                                state_next   = S_RT_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (hold_reg < rd_val)
                begin
                    // Parent moves down into the hole; the hole moves up.
                    wr_data    = rd_val;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            S_RT_RD:
            begin
                res_next = rd_val;
                if (!extract_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    fill_next  = last_idx;
                    rd_addr    = last_idx[ADDR_W-1:0];
                    state_next = S_LAST;
                end
            end

            S_LAST:
            begin
                hold_next = rd_val;
                pos_next  = '0;
                if (fill_reg == '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_DN_RL;
                end
            end

            S_DN_RL:
            begin
                if (lc_idx >= fill_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    rd_addr    = lc_idx[ADDR_W-1:0];
                    state_next = S_DN_RR;
                end
            end

            S_DN_RR:
            begin
                left_next  = rd_val;
                rd_addr    = rc_idx[ADDR_W-1:0];
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (go_right)
                begin
                    wr_data    = rd_val;
                    pos_next   = rc_idx[ADDR_W-1:0];
                    state_next = S_DN_RL;
                end
                else if (go_left)
                begin
                    wr_data    = left_reg;
                    pos_next   = lc_idx[ADDR_W-1:0];
                    state_next = S_DN_RL;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            done_reg    <= 1'b0;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            done_reg    <= done_next;
            extract_reg <= extract_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        hold_reg   <= hold_next;
        left_reg   <= left_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign status       = status_reg;
    assign count        = COUNT_W'(fill_reg);

    // The result pulse always comes with the block ready for the next command.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while busy");

    // An accepted command either keeps the sequencer busy or finishes at once.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done))
        else $error("accepted command was dropped");

    // The heap RAM is only written by a command in progress.
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> busy)
        else $error("RAM written while idle");

    // A full rejection is reported only when the heap really is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (fill_reg == FILL_W'(CAPACITY)))
        else $error("full status with free entries");

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FILL_W'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

// ----- design/mhpq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
